>>> hw/rtl/adsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_pkg: shared types and constants of the ADSR envelope gain block
// Widths, reset values, operation and register codes, sequencer and
// multiply/divide unit types.
// ----------------------------------------------------------------------------
package adsr_pkg;

	localparam int SAMPLE_BITS    = 16;
	localparam int GAIN_FRAC_BITS = 16;

	localparam int GAIN_W = GAIN_FRAC_BITS + 1;
	localparam int CNT_W  = 16;
	localparam int CFG_W  = (GAIN_W > CNT_W) ? GAIN_W : CNT_W;
	localparam int A_W    = (CNT_W > SAMPLE_BITS) ? CNT_W : SAMPLE_BITS;
	localparam int PW     = A_W + GAIN_W;
	localparam int OPB_W  = (GAIN_W > CNT_W) ? GAIN_W : CNT_W;
	localparam int ITER_W = $clog2(PW + 1);

	localparam logic [GAIN_W-1:0] FULL_GAIN = GAIN_W'(1) << GAIN_FRAC_BITS;

	localparam logic [CNT_W-1:0]  RST_ATTACK  = CNT_W'(11025);
	localparam logic [CNT_W-1:0]  RST_DECAY   = CNT_W'(10000);
	localparam logic [GAIN_W-1:0] RST_SUSTAIN = GAIN_W'(1) << (GAIN_FRAC_BITS - 1);
	localparam logic [CNT_W-1:0]  RST_RELEASE = CNT_W'(15000);

	localparam logic [1:0] OP_SAMPLE   = 2'd0;
	localparam logic [1:0] OP_NOTE_ON  = 2'd1;
	localparam logic [1:0] OP_NOTE_OFF = 2'd2;

	localparam logic [1:0] REG_ATTACK  = 2'd0;
	localparam logic [1:0] REG_DECAY   = 2'd1;
	localparam logic [1:0] REG_SUSTAIN = 2'd2;
	localparam logic [1:0] REG_RELEASE = 2'd3;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_ATTACK  = 3'd1,
		PH_DECAY   = 3'd2,
		PH_SUSTAIN = 3'd3,
		PH_RELEASE = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_DIV,
		S_SCALE_GO,
		S_SCALE,
		S_OUT
	} seq_state_t;

	typedef enum logic [1:0] {
		KIND_UP,
		KIND_DOWN_FULL,
		KIND_DOWN_RS
	} ramp_kind_t;

	typedef enum logic {
		MD_MUL,
		MD_DIV
	} md_op_t;

	typedef struct packed {
		logic             start;
		md_op_t           op;
		logic [PW-1:0]    a;
		logic [OPB_W-1:0] b;
	} md_cmd_t;

endpackage

>>> hw/rtl/adsr_muldiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_muldiv: shared iterative multiply / divide unit
// One adder serves a shift-add multiplier (one multiplier bit per cycle)
// and a restoring divider (one quotient bit per cycle).
// ----------------------------------------------------------------------------
module adsr_muldiv (
	input  logic                clk,
	input  logic                arst_n,
	input  adsr_pkg::md_cmd_t   cmd,
	output logic                done,
	output logic [adsr_pkg::PW-1:0] result
);
	import adsr_pkg::*;

	md_op_t              op_q;
	logic                busy_q;
	logic                done_q;
	logic [ITER_W-1:0]   cnt_q;
	logic [PW-1:0]       acc_q;
	logic [PW-1:0]       a_q;
	logic [GAIN_W-1:0]   b_q;
	logic [CNT_W-1:0]    rem_q;

	logic [CNT_W:0]      div_shift;
	logic [PW-1:0]       add_x;
	logic [PW-1:0]       add_y;
	logic                add_sub;
	logic [PW:0]         sum;
	logic                no_borrow;

	always_comb begin
		div_shift = {rem_q, acc_q[PW-1]};
		if (op_q == MD_MUL) begin
			add_x   = acc_q;
			add_y   = b_q[0] ? a_q : '0;
			add_sub = 1'b0;
		end else begin
			add_x   = PW'(div_shift);
			add_y   = a_q;
			add_sub = 1'b1;
		end
		sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)} + (PW+1)'(add_sub);
		no_borrow = sum[PW];
	end

	// control: iteration count and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q   <= MD_MUL;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				op_q   <= cmd.op;
				busy_q <= 1'b1;
				cnt_q  <= (cmd.op == MD_MUL) ? ITER_W'(GAIN_W) : ITER_W'(PW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == ITER_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_q <= (cmd.op == MD_MUL) ? '0 : cmd.a;
			a_q   <= (cmd.op == MD_MUL) ? cmd.a : PW'(cmd.b[CNT_W-1:0]);
			b_q   <= cmd.b[GAIN_W-1:0];
			rem_q <= '0;
		end else if (busy_q) begin
			if (op_q == MD_MUL) begin
				acc_q <= sum[PW-1:0];
				a_q   <= {a_q[PW-2:0], 1'b0};
				b_q   <= {1'b0, b_q[GAIN_W-1:1]};
			end else begin
				// shift in the next dividend bit, keep the difference on no borrow
				rem_q <= no_borrow ? sum[CNT_W-1:0] : div_shift[CNT_W-1:0];
				acc_q <= {acc_q[PW-2:0], no_borrow};
			end
		end
	end

	assign done   = done_q;
	assign result = acc_q;

endmodule

>>> hw/rtl/adsr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_ctrl: envelope state and sequencer
// Steps the envelope phase per item, drives the shared multiply/divide unit
// for ramp and scaling, and holds the result register.
// ----------------------------------------------------------------------------
module adsr_ctrl (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           operation,
	input  logic signed [adsr_pkg::SAMPLE_BITS-1:0] sample_in,
	input  logic [adsr_pkg::CNT_W-1:0]           attack_len,
	input  logic [adsr_pkg::CNT_W-1:0]           decay_len,
	input  logic [adsr_pkg::GAIN_W-1:0]          sustain_lvl,
	input  logic [adsr_pkg::CNT_W-1:0]           release_len,
	output adsr_pkg::md_cmd_t                    md_cmd,
	input  logic                                 md_done,
	input  logic [adsr_pkg::PW-1:0]              md_result,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [adsr_pkg::SAMPLE_BITS-1:0] sample_out,
	output logic [adsr_pkg::GAIN_W-1:0]          gain_now,
	output logic [2:0]                           phase_now,
	output logic                                 release_finished
);
	import adsr_pkg::*;

	seq_state_t state_q, state_d;

	phase_t               phase_q;
	logic [CNT_W-1:0]     counter_q;
	logic [GAIN_W-1:0]    rs_q;
	logic                 done_flag_q;

	logic                 ctrl_q;
	logic                 neg_q;
	logic [SAMPLE_BITS-1:0] mag_q;
	logic [GAIN_W-1:0]    gain_q;
	logic [CNT_W-1:0]     len_q;
	ramp_kind_t           kind_q;

	logic                 out_valid_q;
	logic signed [SAMPLE_BITS-1:0] sample_out_q;
	logic [GAIN_W-1:0]    gain_out_q;
	logic [2:0]           phase_out_q;
	logic                 finished_q;

	logic                 accept;
	logic                 out_free;
	logic                 is_ctrl;
	logic [GAIN_W-1:0]    sus_sat;
	logic [CNT_W-1:0]     cnt_inc;
	logic                 has_ramp;
	logic [CNT_W-1:0]     sel_len;
	logic [GAIN_W-1:0]    sel_span;
	logic [GAIN_W-1:0]    end_gain;
	phase_t               end_phase;
	ramp_kind_t           sel_kind;
	logic                 ramp_end;
	logic                 ramp_go;
	logic [GAIN_W-1:0]    quot;
	logic [GAIN_W-1:0]    ramp_gain;
	logic [SAMPLE_BITS-1:0] mag_in;
	logic signed [PW:0]   prod_s;
	logic signed [PW:0]   prod_sh;

	assign accept   = (state_q == S_IDLE) && in_valid;
	assign out_free = !out_valid_q || !out_stall;
	assign is_ctrl  = (operation != OP_SAMPLE);
	assign in_stall = (state_q != S_IDLE);

	// phase decode for the item at the input
	always_comb begin
		sus_sat   = (sustain_lvl > FULL_GAIN) ? FULL_GAIN : sustain_lvl;
		cnt_inc   = counter_q + 1'b1;
		has_ramp  = 1'b0;
		sel_len   = attack_len;
		sel_span  = FULL_GAIN;
		end_gain  = FULL_GAIN;
		end_phase = PH_DECAY;
		sel_kind  = KIND_UP;
		case (phase_q)
			PH_ATTACK: begin
				has_ramp = 1'b1;
			end
			PH_DECAY: begin
				has_ramp  = 1'b1;
				sel_len   = decay_len;
				sel_span  = FULL_GAIN - sus_sat;
				end_gain  = sus_sat;
				end_phase = PH_SUSTAIN;
				sel_kind  = KIND_DOWN_FULL;
			end
			PH_RELEASE: begin
				has_ramp  = 1'b1;
				sel_len   = release_len;
				sel_span  = rs_q;
				end_gain  = '0;
				end_phase = PH_IDLE;
				sel_kind  = KIND_DOWN_RS;
			end
			default: begin
				has_ramp = 1'b0;
			end
		endcase
		ramp_end = has_ramp && (counter_q >= sel_len);
		ramp_go  = has_ramp && !ramp_end;
		mag_in   = sample_in[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample_in) : SAMPLE_BITS'(sample_in);
	end

	// gain from the ramp quotient
	always_comb begin
		quot = md_result[GAIN_W-1:0];
		case (kind_q)
			KIND_UP:        ramp_gain = quot;
			KIND_DOWN_FULL: ramp_gain = FULL_GAIN - quot;
			KIND_DOWN_RS:   ramp_gain = rs_q - quot;
			default:        ramp_gain = quot;
		endcase
		prod_s  = neg_q ? -$signed({1'b0, md_result}) : $signed({1'b0, md_result});
		prod_sh = prod_s >>> GAIN_FRAC_BITS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		md_cmd.start = 1'b0;
		md_cmd.op    = MD_MUL;
		md_cmd.a     = PW'(cnt_inc);
		md_cmd.b     = OPB_W'(sel_span);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (is_ctrl) begin
						state_d = S_OUT;
					end else if (ramp_go) begin
						md_cmd.start = 1'b1;
						state_d      = S_MUL;
					end else begin
						state_d = S_SCALE_GO;
					end
				end
			end
			S_MUL: begin
				md_cmd.op = MD_DIV;
				md_cmd.a  = md_result;
				md_cmd.b  = OPB_W'(len_q);
				if (md_done) begin
					md_cmd.start = 1'b1;
					state_d      = S_DIV;
				end
			end
			S_DIV: begin
				if (md_done) begin
					state_d = S_SCALE_GO;
				end
			end
			S_SCALE_GO: begin
				md_cmd.start = 1'b1;
				md_cmd.a     = PW'(mag_q);
				md_cmd.b     = OPB_W'(gain_q);
				state_d      = S_SCALE;
			end
			S_SCALE: begin
				if (md_done) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// envelope state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			counter_q   <= '0;
			rs_q        <= '0;
			done_flag_q <= 1'b0;
		end else if (accept) begin
			case (operation)
				OP_NOTE_ON: begin
					phase_q     <= PH_ATTACK;
					counter_q   <= '0;
					done_flag_q <= 1'b0;
				end
				OP_NOTE_OFF: begin
					phase_q   <= PH_RELEASE;
					counter_q <= '0;
				end
				OP_SAMPLE: begin
					if (ramp_end) begin
						counter_q <= '0;
						phase_q   <= end_phase;
						if (phase_q != PH_RELEASE) begin
							rs_q <= end_gain;
						end
					end else if (ramp_go) begin
						counter_q <= cnt_inc;
					end else if (phase_q == PH_SUSTAIN) begin
						rs_q <= sus_sat;
					end else begin
						phase_q     <= PH_IDLE;
						done_flag_q <= 1'b1;
					end
				end
				default: begin
					phase_q <= phase_q;
				end
			endcase
		end else if ((state_q == S_DIV) && md_done && (kind_q != KIND_DOWN_RS)) begin
			rs_q <= ramp_gain;
		end
	end

	// per-item working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			ctrl_q <= is_ctrl;
			neg_q  <= sample_in[SAMPLE_BITS-1];
			mag_q  <= mag_in;
			len_q  <= sel_len;
			kind_q <= sel_kind;
			if (ramp_end) begin
				gain_q <= end_gain;
			end else if (phase_q == PH_SUSTAIN) begin
				gain_q <= sus_sat;
			end else begin
				gain_q <= '0;
			end
		end else if ((state_q == S_DIV) && md_done) begin
			gain_q <= ramp_gain;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_OUT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_OUT) && out_free) begin
			sample_out_q <= ctrl_q ? '0 : prod_sh[SAMPLE_BITS-1:0];
			gain_out_q   <= ctrl_q ? '0 : gain_q;
			phase_out_q  <= phase_q;
			finished_q   <= done_flag_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign sample_out       = sample_out_q;
	assign gain_now         = gain_out_q;
	assign phase_now        = phase_out_q;
	assign release_finished = finished_q;

endmodule

>>> hw/rtl/adsr_envelope_gain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_envelope_gain: linear ADSR envelope applied to audio samples
// Note-on / note-off items steer the envelope phase; sample items advance
// it, form a Q16 gain and scale the sample by that gain.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-----------------------------
//  input    | in        | in_valid / in_stall  | operation, sample_in
//  result   | out       | out_valid / out_stall| sample_out, gain_now,
//           |           |                      | phase_now, release_finished
//  config   | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  Per item: a control item goes straight to the result register; a sample
//  item with a ramp term runs the ramp multiply, the divide and the scale
//  multiply in turn, with sequencing states between; other samples run only
//  the scale multiply.
//  All of it runs through the one shared multiply/divide unit.
//  in_stall is high from the transfer of an item until its result moves to
//  the output register; one finished result may wait there under out_stall
//  while the next item is taken.
//  Reset clears the envelope to idle and loads the configuration defaults;
//  configuration writes are always taken (cfg_ready stays high).
//
module adsr_envelope_gain (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input item channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           operation,
	input  logic signed [adsr_pkg::SAMPLE_BITS-1:0] sample_in,
	// result channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [adsr_pkg::SAMPLE_BITS-1:0] sample_out,
	output logic [adsr_pkg::GAIN_W-1:0]          gain_now,
	output logic [2:0]                           phase_now,
	output logic                                 release_finished,
	// configuration write channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [1:0]                           cfg_index,
	input  logic [adsr_pkg::CFG_W-1:0]           cfg_data
);
	import adsr_pkg::*;

	logic [CNT_W-1:0]  attack_q;
	logic [CNT_W-1:0]  decay_q;
	logic [GAIN_W-1:0] sustain_q;
	logic [CNT_W-1:0]  release_q;

	md_cmd_t           md_cmd;
	logic              md_done;
	logic [PW-1:0]     md_result;

	// Configuration must only be written while no item is in flight (the block
	// does not enforce this), so the registers feed the sequencer directly.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= RST_ATTACK;
			decay_q   <= RST_DECAY;
			sustain_q <= RST_SUSTAIN;
			release_q <= RST_RELEASE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ATTACK:  attack_q  <= cfg_data[CNT_W-1:0];
				REG_DECAY:   decay_q   <= cfg_data[CNT_W-1:0];
				REG_SUSTAIN: sustain_q <= cfg_data[GAIN_W-1:0];
				REG_RELEASE: release_q <= cfg_data[CNT_W-1:0];
				default:     attack_q  <= attack_q;
			endcase
		end
	end

	// Sequencer: phase bookkeeping, ramp term floor(count*span/length),
	// sample scaling and the result register.
	adsr_ctrl u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.operation        (operation),
		.sample_in        (sample_in),
		.attack_len       (attack_q),
		.decay_len        (decay_q),
		.sustain_lvl      (sustain_q),
		.release_len      (release_q),
		.md_cmd           (md_cmd),
		.md_done          (md_done),
		.md_result        (md_result),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.sample_out       (sample_out),
		.gain_now         (gain_now),
		.phase_now        (phase_now),
		.release_finished (release_finished)
	);

	// Shared shift-add multiplier / restoring divider, one bit per cycle.
	adsr_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (md_cmd),
		.done   (md_done),
		.result (md_result)
	);

endmodule

>>> sim/adsr_envelope_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_envelope_check: envelope predictor and result comparator
// Watches the item, result and register channels of adsr_envelope_gain,
// predicts each result and compares it field by field with the block.
// ----------------------------------------------------------------------------
module adsr_envelope_check (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	input  logic                                    in_stall,
	input  logic [1:0]                              operation,
	input  logic signed [adsr_pkg::SAMPLE_BITS-1:0] sample_in,
	input  logic                                    out_valid,
	input  logic                                    out_stall,
	input  logic signed [adsr_pkg::SAMPLE_BITS-1:0] sample_out,
	input  logic [adsr_pkg::GAIN_W-1:0]             gain_now,
	input  logic [2:0]                              phase_now,
	input  logic                                    release_finished,
	input  logic                                    cfg_valid,
	input  logic                                    cfg_ready,
	input  logic [1:0]                              cfg_index,
	input  logic [adsr_pkg::CFG_W-1:0]              cfg_data,
	output int                                      mismatches,
	output int                                      waiting
);
	import adsr_pkg::*;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] smp;
		logic [GAIN_W-1:0]             gain;
		phase_t                        ph;
		logic                          done;
	} env_result_t;

	// register copies
	logic [CNT_W-1:0]  attack_len;
	logic [CNT_W-1:0]  decay_len;
	logic [GAIN_W-1:0] sustain_lvl;
	logic [CNT_W-1:0]  release_len;

	// envelope state
	phase_t            env_phase;
	logic [CNT_W-1:0]  env_cnt;
	logic [GAIN_W-1:0] rel_start;
	logic              env_done;

	env_result_t envelope_q[$];
	env_result_t want;
	int          fails = 0;

	initial begin
		mismatches = 0;
		waiting    = 0;
	end

	function automatic env_result_t envelope_step(logic [1:0] op,
			logic signed [SAMPLE_BITS-1:0] smp);
		env_result_t       r;
		logic [GAIN_W-1:0] g;
		logic [GAIN_W-1:0] sus;
		logic [GAIN_W-1:0] span;
		logic [CNT_W-1:0]  len;
		logic [47:0]       ramp;
		logic              ended;
		longint            prod;
		longint            scaled;
		g      = '0;
		span   = '0;
		len    = '0;
		ramp   = '0;
		ended  = 1'b0;
		scaled = 0;
		sus    = (sustain_lvl > FULL_GAIN) ? FULL_GAIN : sustain_lvl;
		case (op)
			OP_NOTE_ON: begin
				env_cnt   = '0;
				env_done  = 1'b0;
				env_phase = PH_ATTACK;
			end
			OP_NOTE_OFF: begin
				env_phase = PH_RELEASE;
				env_cnt   = '0;
			end
			OP_SAMPLE: begin
				case (env_phase)
					PH_ATTACK: begin
						len  = attack_len;
						span = FULL_GAIN;
					end
					PH_DECAY: begin
						len  = decay_len;
						span = FULL_GAIN - sus;
					end
					PH_RELEASE: begin
						len  = release_len;
						span = rel_start;
					end
					default: ;
				endcase
				// advance the ramp counter; a spent counter ends the phase
				if (env_phase == PH_ATTACK || env_phase == PH_DECAY ||
						env_phase == PH_RELEASE) begin
					if (env_cnt >= len) begin
						env_cnt = '0;
						ended   = 1'b1;
					end else begin
						env_cnt = env_cnt + 1'b1;
						ramp    = (48'(env_cnt) * 48'(span)) / 48'(len);
					end
				end
				case (env_phase)
					PH_ATTACK: begin
						g = ended ? FULL_GAIN : ramp[GAIN_W-1:0];
						if (ended)
							env_phase = PH_DECAY;
						rel_start = g;
					end
					PH_DECAY: begin
						g = ended ? sus : FULL_GAIN - ramp[GAIN_W-1:0];
						if (ended)
							env_phase = PH_SUSTAIN;
						rel_start = g;
					end
					PH_SUSTAIN: begin
						g         = sus;
						rel_start = g;
					end
					PH_RELEASE: begin
						g = ended ? '0 : rel_start - ramp[GAIN_W-1:0];
						if (ended)
							env_phase = PH_IDLE;
					end
					default: begin
						env_phase = PH_IDLE;
						g         = '0;
						env_done  = 1'b1;
					end
				endcase
				// floor of sample * gain / full scale
				prod   = longint'(smp) * longint'(g);
				scaled = prod >>> GAIN_FRAC_BITS;
			end
			default: ;
		endcase
		r.smp  = scaled[SAMPLE_BITS-1:0];
		r.gain = g;
		r.ph   = env_phase;
		r.done = env_done;
		return r;
	endfunction

	function automatic void check_field(string name, longint exp_v, longint got_v);
		if (exp_v != got_v) begin
			fails++;
			$display("%0t: %s expected %0d got %0d", $time, name, exp_v, got_v);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_len  = RST_ATTACK;
			decay_len   = RST_DECAY;
			sustain_lvl = RST_SUSTAIN;
			release_len = RST_RELEASE;
			env_phase   = PH_IDLE;
			env_cnt     = '0;
			rel_start   = '0;
			env_done    = 1'b0;
			envelope_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ATTACK:  attack_len  = cfg_data[CNT_W-1:0];
					REG_DECAY:   decay_len   = cfg_data[CNT_W-1:0];
					REG_SUSTAIN: sustain_lvl = cfg_data[GAIN_W-1:0];
					REG_RELEASE: release_len = cfg_data[CNT_W-1:0];
				endcase
			end
			if (in_valid && !in_stall)
				envelope_q.push_back(envelope_step(operation, sample_in));
			if (out_valid && !out_stall) begin
				if (envelope_q.size() == 0) begin
					fails++;
					$display("%0t: unexpected result sample %0d gain %0d phase %0d",
						$time, sample_out, gain_now, phase_now);
				end else begin
					want = envelope_q.pop_front();
					check_field("sample_out", longint'(want.smp), longint'(sample_out));
					check_field("gain_now", longint'(want.gain), longint'(gain_now));
					check_field("phase_now", longint'(want.ph), longint'(phase_now));
					check_field("release_finished", longint'(want.done),
						longint'(release_finished));
				end
			end
		end
		mismatches <= fails;
		waiting    <= envelope_q.size();
	end

endmodule

>>> sim/adsr_envelope_gain_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_envelope_gain_test: top level of the envelope gain testbench
// Drives note and sample items through a series of register settings, with
// bursty sending and patterned output stalls; the checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module adsr_envelope_gain_test;
	import adsr_pkg::*;

	// operation code the block must ignore
	localparam logic [1:0] OP_UNUSED = 2'd3;
	// longest run of cycles without any transfer before giving up
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTINGS_RUN   = 12;
	localparam int ITEMS_PER_RUN  = 85;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                          in_valid  = 1'b0;
	logic                          in_stall;
	logic [1:0]                    operation = OP_SAMPLE;
	logic signed [SAMPLE_BITS-1:0] sample_in = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic [GAIN_W-1:0]             gain_now;
	logic [2:0]                    phase_now;
	logic                          release_finished;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [1:0]                    cfg_index = REG_ATTACK;
	logic [CFG_W-1:0]              cfg_data  = '0;

	int mismatches;
	int waiting;

	// current lengths, kept to size the note sequences
	int att_len = int'(RST_ATTACK);
	int dec_len = int'(RST_DECAY);
	int rel_len = int'(RST_RELEASE);

	int burst_left = 0;
	int idle_cycles = 0;
	int stall_mode = 0;
	int mode_left = 0;
	int run_left = 0;

	always #10 clk = ~clk;

	adsr_envelope_gain u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.operation        (operation),
		.sample_in        (sample_in),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.sample_out       (sample_out),
		.gain_now         (gain_now),
		.phase_now        (phase_now),
		.release_finished (release_finished),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	adsr_envelope_check u_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.operation        (operation),
		.sample_in        (sample_in),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.sample_out       (sample_out),
		.gain_now         (gain_now),
		.phase_now        (phase_now),
		.release_finished (release_finished),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.mismatches       (mismatches),
		.waiting          (waiting)
	);

	// Receiver: switch between stall patterns at random intervals - no
	// stall at all, sparse stalls, dense stalls, and long stall/run stretches.
	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			mode_left  <= $urandom_range(20, 200);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: begin
				if (run_left == 0) begin
					out_stall <= ~out_stall;
					run_left  <= $urandom_range(1, 30);
				end else begin
					run_left <= run_left - 1;
				end
			end
		endcase
	end

	// Watchdog: any transfer on any channel restarts the count.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Mostly random samples, with the full-scale extremes mixed in.
	function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return '0;
			3: return '1;
			default: return SAMPLE_BITS'($urandom());
		endcase
	endfunction

	// Pick a phase length: mostly short so notes run through every phase,
	// sometimes 0, 1, 63500 or anything the 16-bit field can hold.
	function automatic logic [CNT_W-1:0] pick_len();
		int r;
		r = $urandom_range(0, 19);
		if (r < 13)
			return CNT_W'($urandom_range(0, 10));
		else if (r == 13)
			return '0;
		else if (r == 14)
			return CNT_W'(1);
		else if (r == 15)
			return CNT_W'(63500);
		else
			return CNT_W'($urandom());
	endfunction

	function automatic logic [GAIN_W-1:0] pick_sustain();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return FULL_GAIN;
			2: return GAIN_W'($urandom_range(int'(FULL_GAIN) + 1, (1 << GAIN_W) - 1));
			3: return '1;
			default: return GAIN_W'($urandom_range(0, int'(FULL_GAIN)));
		endcase
	endfunction

	// Cap on how many samples a phase of this length needs to be walked through.
	function automatic int walk_of(int len);
		return (len > 30) ? 30 : len + 1;
	endfunction

	// Send one item. Open a new burst after a random gap when the current one
	// is used up; hold valid and payload until the transfer.
	task automatic send_item(input logic [1:0] op, input logic signed [SAMPLE_BITS-1:0] smp);
		int gap;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
			burst_left = $urandom_range(1, 40);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid  <= 1'b1;
		operation <= op;
		sample_in <= smp;
		do @(posedge clk); while (in_stall);
	endtask

	// Drop valid and wait until every expected result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (waiting != 0);
	endtask

	// Write all four registers back to back; only called with the block drained.
	task automatic apply_setting(input logic [CNT_W-1:0] a, input logic [CNT_W-1:0] d,
			input logic [GAIN_W-1:0] s, input logic [CNT_W-1:0] r);
		logic [1:0]       idx [4] = '{REG_ATTACK, REG_DECAY, REG_SUSTAIN, REG_RELEASE};
		logic [CFG_W-1:0] vals [4];
		// the spare top bit of the length registers must be ignored
		vals[0] = {1'($urandom_range(0, 1)), a};
		vals[1] = {1'($urandom_range(0, 1)), d};
		vals[2] = s;
		vals[3] = {1'($urandom_range(0, 1)), r};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= vals[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		att_len = int'(a);
		dec_len = int'(d);
		rel_len = int'(r);
	endtask

	// Mostly complete notes (note on, walk through attack/decay/sustain,
	// note off, walk through release into idle) with random sample content;
	// the rest is noise: random operations, stray note-offs and restarts.
	task automatic play_notes(input int budget);
		int         sent;
		int         n;
		logic [1:0] op;
		sent = 0;
		while (sent < budget) begin
			if ($urandom_range(0, 9) < 7) begin
				send_item(OP_NOTE_ON, rand_sample());
				n = $urandom_range(0, walk_of(att_len) + walk_of(dec_len) + 6);
				for (int k = 0; k < n; k++)
					send_item(OP_SAMPLE, rand_sample());
				sent += n + 2;
				send_item(OP_NOTE_OFF, rand_sample());
				n = $urandom_range(0, walk_of(rel_len) + 4);
				for (int k = 0; k < n; k++)
					send_item(OP_SAMPLE, rand_sample());
				sent += n;
			end else begin
				n = $urandom_range(1, 6);
				for (int k = 0; k < n; k++) begin
					op = 2'($urandom_range(0, 3));
					send_item(op, rand_sample());
					if (op != OP_UNUSED)
						sent++;
				end
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: idle samples set release-done, the unused code is
		// ignored, note-off while idle releases from zero, then a slow attack.
		send_item(OP_SAMPLE, 16'sh7FFF);
		send_item(OP_SAMPLE, 16'sh8000);
		send_item(OP_UNUSED, 16'sh1234);
		send_item(OP_NOTE_OFF, '0);
		send_item(OP_SAMPLE, 16'sd1000);
		send_item(OP_NOTE_ON, '0);
		send_item(OP_SAMPLE, 16'sh7FFF);
		send_item(OP_SAMPLE, 16'sh8000);
		send_item(OP_SAMPLE, -16'sd1);
		send_item(OP_NOTE_OFF, '0);
		send_item(OP_SAMPLE, 16'sh7FFF);
		drain();

		// Zero lengths end each phase on its first sample; sustain above
		// full scale saturates.
		apply_setting('0, '0, '1, '0);
		send_item(OP_NOTE_ON, '0);
		send_item(OP_SAMPLE, 16'sh8000);
		send_item(OP_SAMPLE, 16'sh7FFF);
		send_item(OP_SAMPLE, 16'sd12345);
		send_item(OP_NOTE_OFF, '0);
		send_item(OP_SAMPLE, -16'sd12345);
		send_item(OP_SAMPLE, 16'sh7FFF);
		send_item(OP_NOTE_ON, '0);
		send_item(OP_SAMPLE, -16'sd1);
		send_item(OP_UNUSED, 16'sh8000);
		drain();

		// Random part: a fresh register setting per run, extremes first.
		for (int k = 0; k < SETTINGS_RUN; k++) begin
			case (k)
				0: apply_setting('0, '0, '0, '0);
				1: apply_setting('1, '1, '1, '1);
				2: apply_setting(CNT_W'(63500), CNT_W'(63500), FULL_GAIN, CNT_W'(63500));
				default: apply_setting(pick_len(), pick_len(), pick_sustain(), pick_len());
			endcase
			play_notes(ITEMS_PER_RUN);
			drain();
		end

		// let any stray result show up before the verdict
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> adsr_envelope_gain.f
hw/rtl/adsr_pkg.sv
hw/rtl/adsr_muldiv.sv
hw/rtl/adsr_ctrl.sv
hw/rtl/adsr_envelope_gain.sv
sim/adsr_envelope_check.sv
sim/adsr_envelope_gain_test.sv
